@@ design/gts_pkg.sv @@
package gts_pkg;

  localparam int TIMER_BITS_DEF = 32;
  localparam int DATA_BYTES     = 12;
  localparam int IDX_W          = 4;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 32;
  localparam int WORD_W         = 32;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_BYTE    = 2'd2,
    CMD_WR_DONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_SEND   = 2'd0,
    ACT_PMIC   = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    SEL_PREP    = 2'd0,
    SEL_GLITCH  = 2'd1,
    SEL_RESTORE = 2'd2
  } pmic_sel_t;

  typedef enum logic [3:0] {
    ST_UNREACHABLE   = 4'd0,
    ST_UNCONNECTABLE = 4'd1,
    ST_UNTRIGGERED   = 4'd2,
    ST_PMIC_FAIL     = 4'd3,
    ST_DEAD          = 4'd4,
    ST_NORMAL        = 4'd5,
    ST_SUCCESS       = 4'd6,
    ST_DATA_TIMEOUT  = 4'd7,
    ST_RESET         = 4'd8,
    ST_ZOMBIE        = 4'd9
  } status_t;

  typedef enum logic [9:0] {
    PH_IDLE       = 10'b00_0000_0001,
    PH_WAIT_READY = 10'b00_0000_0010,
    PH_WAIT_TRIG  = 10'b00_0000_0100,
    PH_PREP_WR    = 10'b00_0000_1000,
    PH_OFFSET     = 10'b00_0001_0000,
    PH_GLITCH_WR  = 10'b00_0010_0000,
    PH_WIDTH      = 10'b00_0100_0000,
    PH_RESTORE_WR = 10'b00_1000_0000,
    PH_WAIT_REPLY = 10'b01_0000_0000,
    PH_COLLECT    = 10'b10_0000_0000
  } phase_t;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_TO = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_READY   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONNECT = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SUCCESS = 4'd7;

  typedef struct packed {
    action_t          action;
    logic [7:0]       tx_data;
    pmic_sel_t        pmic_select;
    status_t          status;
    logic [WORD_W-1:0] performed_count;
    logic [WORD_W-1:0] first_result;
    logic [WORD_W-1:0] second_result;
  } result_t;

endpackage

@@ design/gts_ctrl.sv @@
module gts_ctrl #(
  parameter int TIMER_BITS = gts_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_accept,
  input  logic [1:0]                     in_command,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           in_write_ok,
  input  logic                           cfg_we,
  input  logic [gts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gts_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           res_valid,
  output gts_pkg::result_t               res
);
  import gts_pkg::*;

  localparam int CMP_W = (TIMER_BITS > 32) ? TIMER_BITS : 32;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BYTES - 1);

  logic [31:0] offset_r, width_r, reply_to_r;
  logic [15:0] data_to_r;
  logic [7:0]  ready_code_r, connect_code_r, normal_code_r, success_code_r;

  phase_t                 phase_r, phase_nxt;
  logic [TIMER_BITS-1:0]  elapsed_r, elapsed_nxt, el_inc;
  logic                   wf_r, wf_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [3*WORD_W-1:0]    words_r, words_nxt;
  logic                   held_v_r, held_v_nxt;
  logic [7:0]             held_r, held_nxt;

  cmd_t        cmd;
  logic        take, adv, fin;
  logic [7:0]  tb;
  phase_t      tphase;
  status_t     fin_st;
  logic [CMP_W-1:0] inc_x, off_x, wid_x, rto_x, dto_x;

  assign cmd    = cmd_t'(in_command);
  assign el_inc = (&elapsed_r) ? elapsed_r : elapsed_r + TIMER_BITS'(1);
  assign inc_x  = CMP_W'(el_inc);
  assign off_x  = CMP_W'(offset_r);
  assign wid_x  = CMP_W'(width_r);
  assign rto_x  = CMP_W'(reply_to_r);
  assign dto_x  = CMP_W'(data_to_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r       <= '0;
      width_r        <= '0;
      reply_to_r     <= 32'd100000;
      data_to_r      <= 16'd1000;
      ready_code_r   <= 8'd82;
      connect_code_r <= 8'd67;
      normal_code_r  <= 8'd78;
      success_code_r <= 8'd83;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET:  offset_r       <= cfg_data;
        REG_WIDTH:   width_r        <= cfg_data;
        REG_REPLY:   reply_to_r     <= cfg_data;
        REG_DATA_TO: data_to_r      <= cfg_data[15:0];
        REG_READY:   ready_code_r   <= cfg_data[7:0];
        REG_CONNECT: connect_code_r <= cfg_data[7:0];
        REG_NORMAL:  normal_code_r  <= cfg_data[7:0];
        REG_SUCCESS: success_code_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    wf_nxt      = wf_r;
    idx_nxt     = idx_r;
    words_nxt   = words_r;
    held_v_nxt  = held_v_r;
    held_nxt    = held_r;
    res_valid   = 1'b0;
    res         = '0;
    take        = 1'b0;
    adv         = 1'b0;
    fin         = 1'b0;
    fin_st      = ST_UNREACHABLE;
    tb          = held_r;
    tphase      = phase_r;

    unique case (cmd)
      CMD_START: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt   = PH_WAIT_READY;
          elapsed_nxt = '0;
          wf_nxt      = 1'b0;
          idx_nxt     = '0;
          tphase      = PH_WAIT_READY;
          take        = held_v_r;
        end
      end
      CMD_TICK: begin
        unique case (phase_r)
          PH_OFFSET: begin
            elapsed_nxt = el_inc;
            if (inc_x >= off_x) begin
              phase_nxt         = PH_GLITCH_WR;
              res_valid         = 1'b1;
              res.action        = ACT_PMIC;
              res.pmic_select   = SEL_GLITCH;
            end
          end
          PH_WIDTH: begin
            elapsed_nxt = el_inc;
            if (inc_x >= wid_x) begin
              phase_nxt         = PH_RESTORE_WR;
              res_valid         = 1'b1;
              res.action        = ACT_PMIC;
              res.pmic_select   = SEL_RESTORE;
            end
          end
          PH_WAIT_READY: begin
            elapsed_nxt = el_inc;
            if (inc_x > rto_x) begin
              fin    = 1'b1;
              fin_st = ST_UNREACHABLE;
            end
          end
          PH_WAIT_TRIG: begin
            elapsed_nxt = el_inc;
            if (inc_x > rto_x) begin
              fin    = 1'b1;
              fin_st = ST_UNTRIGGERED;
            end
          end
          PH_WAIT_REPLY: begin
            elapsed_nxt = el_inc;
            if (inc_x > rto_x) begin
              fin    = 1'b1;
              fin_st = ST_DEAD;
            end
          end
          PH_COLLECT: begin
            elapsed_nxt = el_inc;
            if (inc_x > dto_x) begin
              wf_nxt = 1'b1;
              adv    = 1'b1;
            end
          end
          default: ;
        endcase
      end
      CMD_BYTE: begin
        if (phase_r == PH_WAIT_READY || phase_r == PH_WAIT_TRIG ||
            phase_r == PH_WAIT_REPLY || phase_r == PH_COLLECT) begin
          take = 1'b1;
          tb   = in_rx_byte;
        end else begin
          held_v_nxt = 1'b1;
          held_nxt   = in_rx_byte;
        end
      end
      CMD_WR_DONE: begin
        if (phase_r == PH_PREP_WR || phase_r == PH_GLITCH_WR) begin
          if (!in_write_ok) wf_nxt = 1'b1;
          elapsed_nxt = '0;
          if (phase_r == PH_PREP_WR) begin
            phase_nxt = PH_OFFSET;
            if (offset_r == '0) begin
              phase_nxt       = PH_GLITCH_WR;
              res_valid       = 1'b1;
              res.action      = ACT_PMIC;
              res.pmic_select = SEL_GLITCH;
            end
          end else begin
            phase_nxt = PH_WIDTH;
            if (width_r == '0) begin
              phase_nxt       = PH_RESTORE_WR;
              res_valid       = 1'b1;
              res.action      = ACT_PMIC;
              res.pmic_select = SEL_RESTORE;
            end
          end
        end else if (phase_r == PH_RESTORE_WR) begin
          if (!in_write_ok || wf_r) begin
            wf_nxt = 1'b1;
            fin    = 1'b1;
            fin_st = ST_PMIC_FAIL;
          end else begin
            phase_nxt   = PH_WAIT_REPLY;
            elapsed_nxt = '0;
            tphase      = PH_WAIT_REPLY;
            take        = held_v_r;
          end
        end
      end
      default: ;
    endcase

    if (take) begin
      held_v_nxt = 1'b0;
      held_nxt   = '0;
      unique case (tphase)
        PH_WAIT_READY: begin
          if (tb != ready_code_r) begin
            fin    = 1'b1;
            fin_st = ST_UNCONNECTABLE;
          end else begin
            phase_nxt   = PH_WAIT_TRIG;
            elapsed_nxt = '0;
            res_valid   = 1'b1;
            res.action  = ACT_SEND;
            res.tx_data = connect_code_r;
          end
        end
        PH_WAIT_TRIG: begin
          phase_nxt       = PH_PREP_WR;
          res_valid       = 1'b1;
          res.action      = ACT_PMIC;
          res.pmic_select = SEL_PREP;
        end
        PH_WAIT_REPLY: begin
          if (tb == normal_code_r) begin
            fin    = 1'b1;
            fin_st = ST_NORMAL;
          end else if (tb == success_code_r) begin
            phase_nxt   = PH_COLLECT;
            idx_nxt     = '0;
            elapsed_nxt = '0;
            wf_nxt      = 1'b0;
          end else if (tb == ready_code_r) begin
            fin    = 1'b1;
            fin_st = ST_RESET;
          end else begin
            fin    = 1'b1;
            fin_st = ST_ZOMBIE;
          end
        end
        PH_COLLECT: begin
          words_nxt[{idx_r, 3'b000} +: 8] = tb;
          adv = 1'b1;
        end
        default: ;
      endcase
    end

    if (adv) begin
      idx_nxt     = idx_r + IDX_W'(1);
      elapsed_nxt = '0;
      if (idx_r >= LAST_IDX) begin
        fin    = 1'b1;
        fin_st = wf_nxt ? ST_DATA_TIMEOUT : ST_SUCCESS;
      end
    end

    if (fin) begin
      phase_nxt  = PH_IDLE;
      res_valid  = 1'b1;
      res.action = ACT_FINISH;
      res.status = fin_st;
      if (fin_st == ST_SUCCESS) begin
        res.performed_count = words_nxt[WORD_W-1:0];
        res.first_result    = words_nxt[2*WORD_W-1:WORD_W];
        res.second_result   = words_nxt[3*WORD_W-1:2*WORD_W];
      end
    end

    if (!in_accept) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      wf_r      <= 1'b0;
      idx_r     <= '0;
      held_v_r  <= 1'b0;
      held_r    <= '0;
    end else if (in_accept) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      wf_r      <= wf_nxt;
      idx_r     <= idx_nxt;
      held_v_r  <= held_v_nxt;
      held_r    <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      words_r <= words_nxt;
    end
  end

endmodule

@@ design/gts_skid.sv @@
module gts_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  gts_pkg::result_t res,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output gts_pkg::result_t out_res
);
  import gts_pkg::*;

  logic    out_v_r, out_v_nxt, sk_v_r, sk_v_nxt;
  result_t out_r, out_nxt, sk_r, sk_nxt;

  always_comb begin
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    sk_v_nxt  = sk_v_r;
    sk_nxt    = sk_r;
    if (out_v_r && !out_stall) begin
      if (sk_v_r) begin
        out_nxt  = sk_r;
        sk_v_nxt = 1'b0;
      end else begin
        out_v_nxt = 1'b0;
      end
    end
    if (res_valid) begin
      if (!out_v_nxt) begin
        out_v_nxt = 1'b1;
        out_nxt   = res;
      end else begin
        sk_v_nxt = 1'b1;
        sk_nxt   = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    sk_r  <= sk_nxt;
  end

  assign full      = sk_v_r;
  assign out_valid = out_v_r;
  assign out_res   = out_r;

endmodule

@@ design/glitch_trigger_sequencer_core.sv @@
// Sequences one voltage-glitch attempt from start, microsecond-tick, target-byte and
// PMIC-write-done transactions. Every input transaction is handled in the cycle it is
// accepted, so one transaction per cycle is sustained while in_stall is low; any result
// is registered into the output buffer. A two-entry output buffer lets input continue
// while a result is stalled; in_stall rises only when both entries are occupied.
// Configuration writes are always ready and must be issued while the sequencer is idle.
module glitch_trigger_sequencer_core #(
  parameter int TIMER_BITS = gts_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_command,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           in_write_ok,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_action,
  output logic [7:0]                     out_tx_data,
  output logic [1:0]                     out_pmic_select,
  output logic [3:0]                     out_status,
  output logic [gts_pkg::WORD_W-1:0]     out_performed_count,
  output logic [gts_pkg::WORD_W-1:0]     out_first_result,
  output logic [gts_pkg::WORD_W-1:0]     out_second_result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gts_pkg::*;

  logic    in_accept, res_valid, full;
  result_t res, out_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign in_accept = in_valid && !full;

  gts_ctrl #(
    .TIMER_BITS (TIMER_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .in_command  (in_command),
    .in_rx_byte  (in_rx_byte),
    .in_write_ok (in_write_ok),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  gts_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_action          = out_res.action;
  assign out_tx_data         = out_res.tx_data;
  assign out_pmic_select     = out_res.pmic_select;
  assign out_status          = out_res.status;
  assign out_performed_count = out_res.performed_count;
  assign out_first_result    = out_res.first_result;
  assign out_second_result   = out_res.second_result;

endmodule
